### hdl/ofr_pkg.sv
// Package with the types and constants shared by the frame receiver files.
package ofr_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned POS_W        = 5;
   localparam int unsigned CRC_W        = 16;
   localparam int unsigned KEY_W        = 32;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned MAX_PAYLOAD  = 24;

   localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'hAB;
   localparam logic [BYTE_W-1:0] SYNC2_BYTE = 8'hCD;
   localparam logic [BYTE_W-1:0] FOOT1_BYTE = 8'hDC;
   localparam logic [BYTE_W-1:0] FOOT2_BYTE = 8'hBA;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [KEY_W-1:0] KEY0_RESET = 32'd3860098070;
   localparam logic [KEY_W-1:0] KEY1_RESET = 32'd1074630958;
   localparam logic [KEY_W-1:0] KEY2_RESET = 32'd1087714593;
   localparam logic [KEY_W-1:0] KEY3_RESET = 32'd2162754323;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY0 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY1 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY3 = 2'd3;

   typedef enum logic [3:0] {
      ST_SYNC1,
      ST_SYNC2,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_DATA,
      ST_CRC_SHIFT,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_FOOT1,
      ST_FOOT2,
      ST_EMIT_READ,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

endpackage

### hdl/ofr_req_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface ofr_req_if;
   logic                          valid;
   logic                          ready;
   logic [ofr_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ofr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ofr_pkg::BYTE_W-1:0]    payload_byte;
   logic [ofr_pkg::POS_W-1:0]     byte_position;
   logic                          has_byte;
   logic                          last;
   logic [ofr_pkg::POS_W-1:0]     frame_length;

   modport source (output valid, output payload_byte, output byte_position,
                   output has_byte, output last, output frame_length, input ready);
   modport sink   (input valid, input payload_byte, input byte_position,
                   input has_byte, input last, input frame_length, output ready);
endinterface

### hdl/obfuscated_frame_receiver_core.sv
// Top level of the obfuscated frame receiver: framing, key XOR, CRC check, payload replay.
//
//   channel    direction  payload                                          transfer
//   req_chan   in         rx_byte                                          valid & ready
//   rsp_chan   out        payload_byte, byte_position, has_byte, last,     valid & ready
//                         frame_length
//   csr_*      in         csr_index, csr_wdata (key words 0..3)            csr_wen
//
// Header, length, CRC and footer bytes each take one transfer. A payload byte is taken, then
// the single shift/XOR CRC unit handles its bits one at a time while no byte is taken.
// An accepted frame then gives its results one after another, each through RAM read,
// output load and transfer, waiting while rsp_chan.ready is low; no byte is taken until
// the last result has been transferred. Reset loads the key words with their defaults and
// returns to hunting for the first sync byte; the payload RAM is not cleared.
module obfuscated_frame_receiver_core (
   input  logic                                clock,
   input  logic                                reset,
   ofr_req_if.sink                             req_chan,
   ofr_rsp_if.source                           rsp_chan,
   input  logic                                csr_wen,
   input  logic [ofr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ofr_pkg::KEY_W-1:0]           csr_wdata
);

   localparam int unsigned ADDR_W = $clog2(ofr_pkg::MAX_PAYLOAD);

   ofr_pkg::state_type state_ff, state_in;

   logic [ofr_pkg::KEY_W-1:0]  key0_ff, key1_ff, key2_ff, key3_ff;
   logic [ofr_pkg::BYTE_W-1:0] length_low_ff, length_low_in;
   logic [ofr_pkg::POS_W-1:0]  payload_length_ff, payload_length_in;
   logic [ofr_pkg::POS_W-1:0]  byte_count_ff, byte_count_in;
   logic [ofr_pkg::CRC_W-1:0]  crc_running_ff, crc_running_in;
   logic [ofr_pkg::CRC_W-1:0]  crc_received_ff, crc_received_in;
   logic [2:0]                 bit_count_ff, bit_count_in;
   logic [ofr_pkg::POS_W-1:0]  emit_idx_ff, emit_idx_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ofr_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [ofr_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                       rsp_has_ff, rsp_has_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [ofr_pkg::POS_W-1:0]  rsp_len_ff, rsp_len_in;

   logic                       req_ready;
   logic                       req_xfer;
   logic                       rsp_xfer;
   logic [ofr_pkg::BYTE_W-1:0] rx_b;
   logic [15:0]                len_full;
   logic [ofr_pkg::BYTE_W-1:0] data_plain;
   logic                       frame_good;

   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [ofr_pkg::BYTE_W-1:0] ram_rd_data;

   function automatic logic [ofr_pkg::BYTE_W-1:0] key_byte(
      input logic [3:0]                pos,
      input logic [ofr_pkg::KEY_W-1:0] w0,
      input logic [ofr_pkg::KEY_W-1:0] w1,
      input logic [ofr_pkg::KEY_W-1:0] w2,
      input logic [ofr_pkg::KEY_W-1:0] w3
   );
      logic [ofr_pkg::KEY_W-1:0] w;
      case (pos[3:2])
         2'd0:    w = w0;
         2'd1:    w = w1;
         2'd2:    w = w2;
         default: w = w3;
      endcase
      return w[pos[1:0]*8 +: 8];
   endfunction

   assign rx_b      = req_chan.rx_byte;
   assign req_xfer  = req_chan.valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_chan.ready;
   assign len_full  = {rx_b, length_low_ff};
   assign data_plain = rx_b ^ key_byte(byte_count_ff[3:0], key0_ff, key1_ff, key2_ff, key3_ff);
   assign frame_good = (rx_b == ofr_pkg::FOOT2_BYTE) && (crc_received_ff == crc_running_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ofr_pkg::ST_SYNC1: begin
            if (req_xfer && rx_b == ofr_pkg::SYNC1_BYTE) begin
               state_in = ofr_pkg::ST_SYNC2;
            end
         end
         ofr_pkg::ST_SYNC2: begin
            if (req_xfer) begin
               if (rx_b == ofr_pkg::SYNC2_BYTE) begin
                  state_in = ofr_pkg::ST_LEN_LO;
               end else if (rx_b != ofr_pkg::SYNC1_BYTE) begin
                  state_in = ofr_pkg::ST_SYNC1;
               end
            end
         end
         ofr_pkg::ST_LEN_LO: begin
            if (req_xfer) begin
               state_in = ofr_pkg::ST_LEN_HI;
            end
         end
         ofr_pkg::ST_LEN_HI: begin
            if (req_xfer) begin
               if (len_full > 16'(ofr_pkg::MAX_PAYLOAD)) begin
                  state_in = ofr_pkg::ST_SYNC1;
               end else if (len_full == 16'd0) begin
                  state_in = ofr_pkg::ST_CRC_LO;
               end else begin
                  state_in = ofr_pkg::ST_DATA;
               end
            end
         end
         ofr_pkg::ST_DATA: begin
            if (req_xfer) begin
               state_in = ofr_pkg::ST_CRC_SHIFT;
            end
         end
         ofr_pkg::ST_CRC_SHIFT: begin
            if (bit_count_ff == 3'd7) begin
               if (byte_count_ff >= payload_length_ff) begin
                  state_in = ofr_pkg::ST_CRC_LO;
               end else begin
                  state_in = ofr_pkg::ST_DATA;
               end
            end
         end
         ofr_pkg::ST_CRC_LO: begin
            if (req_xfer) begin
               state_in = ofr_pkg::ST_CRC_HI;
            end
         end
         ofr_pkg::ST_CRC_HI: begin
            if (req_xfer) begin
               state_in = ofr_pkg::ST_FOOT1;
            end
         end
         ofr_pkg::ST_FOOT1: begin
            if (req_xfer) begin
               state_in = (rx_b == ofr_pkg::FOOT1_BYTE) ? ofr_pkg::ST_FOOT2
                                                        : ofr_pkg::ST_SYNC1;
            end
         end
         ofr_pkg::ST_FOOT2: begin
            if (req_xfer) begin
               if (!frame_good) begin
                  state_in = ofr_pkg::ST_SYNC1;
               end else if (payload_length_ff == '0) begin
                  state_in = ofr_pkg::ST_EMIT_WAIT;
               end else begin
                  state_in = ofr_pkg::ST_EMIT_READ;
               end
            end
         end
         ofr_pkg::ST_EMIT_READ: begin
            state_in = ofr_pkg::ST_EMIT_LOAD;
         end
         ofr_pkg::ST_EMIT_LOAD: begin
            state_in = ofr_pkg::ST_EMIT_WAIT;
         end
         ofr_pkg::ST_EMIT_WAIT: begin
            if (rsp_xfer) begin
               state_in = rsp_last_ff ? ofr_pkg::ST_SYNC1 : ofr_pkg::ST_EMIT_READ;
            end
         end
         default: begin
            state_in = ofr_pkg::ST_SYNC1;
         end
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      req_ready         = 1'b0;
      ram_wr_en         = 1'b0;
      ram_rd_en         = 1'b0;
      length_low_in     = length_low_ff;
      payload_length_in = payload_length_ff;
      byte_count_in     = byte_count_ff;
      crc_running_in    = crc_running_ff;
      crc_received_in   = crc_received_ff;
      bit_count_in      = bit_count_ff;
      emit_idx_in       = emit_idx_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_xfer;
      rsp_byte_in       = rsp_byte_ff;
      rsp_pos_in        = rsp_pos_ff;
      rsp_has_in        = rsp_has_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_len_in        = rsp_len_ff;
      case (state_ff)
         ofr_pkg::ST_SYNC1, ofr_pkg::ST_SYNC2, ofr_pkg::ST_CRC_HI, ofr_pkg::ST_FOOT1: begin
            req_ready = 1'b1;
            if (req_xfer && state_ff == ofr_pkg::ST_CRC_HI) begin
               crc_received_in[15:8] = rx_b ^ key_byte(payload_length_ff[3:0] + 4'd1,
                                                       key0_ff, key1_ff, key2_ff, key3_ff);
            end
         end
         ofr_pkg::ST_LEN_LO: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               length_low_in = rx_b;
            end
         end
         ofr_pkg::ST_LEN_HI: begin
            req_ready = 1'b1;
            if (req_xfer && len_full <= 16'(ofr_pkg::MAX_PAYLOAD)) begin
               payload_length_in = len_full[ofr_pkg::POS_W-1:0];
               byte_count_in     = '0;
               crc_running_in    = '0;
            end
         end
         ofr_pkg::ST_DATA: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               ram_wr_en      = 1'b1;
               crc_running_in = crc_running_ff ^ {data_plain, 8'h00};
               byte_count_in  = byte_count_ff + 1'b1;
               bit_count_in   = '0;
            end
         end
         ofr_pkg::ST_CRC_SHIFT: begin
            // One bit of the CRC division per cycle.
            crc_running_in = crc_running_ff[15]
                           ? ({crc_running_ff[14:0], 1'b0} ^ ofr_pkg::CRC_POLY)
                           : {crc_running_ff[14:0], 1'b0};
            bit_count_in   = bit_count_ff + 1'b1;
         end
         ofr_pkg::ST_CRC_LO: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               crc_received_in = {8'h00, rx_b ^ key_byte(payload_length_ff[3:0],
                                                         key0_ff, key1_ff, key2_ff, key3_ff)};
            end
         end
         ofr_pkg::ST_FOOT2: begin
            req_ready = 1'b1;
            if (req_xfer && frame_good) begin
               emit_idx_in = '0;
               if (payload_length_ff == '0) begin
                  // Empty frame: a single marker result.
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = '0;
                  rsp_pos_in   = '0;
                  rsp_has_in   = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_len_in   = '0;
               end
            end
         end
         ofr_pkg::ST_EMIT_READ: begin
            ram_rd_en = 1'b1;
         end
         ofr_pkg::ST_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = ram_rd_data;
            rsp_pos_in   = emit_idx_ff;
            rsp_has_in   = 1'b1;
            rsp_last_in  = (ofr_pkg::POS_W'(emit_idx_ff + 1'b1) == payload_length_ff);
            rsp_len_in   = payload_length_ff;
         end
         ofr_pkg::ST_EMIT_WAIT: begin
            if (rsp_xfer) begin
               emit_idx_in = emit_idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ofr_pkg::ST_SYNC1;
         key0_ff           <= ofr_pkg::KEY0_RESET;
         key1_ff           <= ofr_pkg::KEY1_RESET;
         key2_ff           <= ofr_pkg::KEY2_RESET;
         key3_ff           <= ofr_pkg::KEY3_RESET;
         length_low_ff     <= '0;
         payload_length_ff <= '0;
         byte_count_ff     <= '0;
         crc_running_ff    <= '0;
         crc_received_ff   <= '0;
         bit_count_ff      <= '0;
         emit_idx_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         length_low_ff     <= length_low_in;
         payload_length_ff <= payload_length_in;
         byte_count_ff     <= byte_count_in;
         crc_running_ff    <= crc_running_in;
         crc_received_ff   <= crc_received_in;
         bit_count_ff      <= bit_count_in;
         emit_idx_ff       <= emit_idx_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               ofr_pkg::CSR_KEY0: key0_ff <= csr_wdata;
               ofr_pkg::CSR_KEY1: key1_ff <= csr_wdata;
               ofr_pkg::CSR_KEY2: key2_ff <= csr_wdata;
               ofr_pkg::CSR_KEY3: key3_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   ofr_ram #(
      .WIDTH (ofr_pkg::BYTE_W),
      .DEPTH (ofr_pkg::MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (byte_count_ff[ADDR_W-1:0]),
      .wr_data (data_plain),
      .rd_en   (ram_rd_en),
      .rd_addr (emit_idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // No byte is taken while reset is held.
   assign req_chan.ready         = req_ready && !reset;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.payload_byte  = rsp_byte_ff;
   assign rsp_chan.byte_position = rsp_pos_ff;
   assign rsp_chan.has_byte      = rsp_has_ff;
   assign rsp_chan.last          = rsp_last_ff;
   assign rsp_chan.frame_length  = rsp_len_ff;

endmodule

### hdl/ofr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ofr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 24
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
